// ===== design/fpln_pkg.sv =====
// Package for the fixed-point natural log core: widths, constants, series table.
// No dependencies.
`default_nettype none
package fpln_pkg;
  localparam int unsigned InW    = 32;
  localparam int unsigned LogW   = 21;
  localparam int unsigned MantW  = 17;
  localparam int unsigned YW     = 17;  // y in [-21845, 0], signed
  localparam int unsigned QW     = 15;  // quotient magnitude bits
  localparam int unsigned AccW   = 18;  // Horner accumulator, signed
  localparam int unsigned NTerms = 11;
  localparam int signed   Ln2Q16 = 45426;

  // 65536 / (2k + 1), truncated
  function automatic logic signed [AccW-1:0] series_coef(input int unsigned k);
    unique case (k)
      0:       series_coef = AccW'(65536);
      1:       series_coef = AccW'(21845);
      2:       series_coef = AccW'(13107);
      3:       series_coef = AccW'(9362);
      4:       series_coef = AccW'(7281);
      5:       series_coef = AccW'(5957);
      6:       series_coef = AccW'(5041);
      7:       series_coef = AccW'(4369);
      8:       series_coef = AccW'(3855);
      9:       series_coef = AccW'(3449);
      default: series_coef = AccW'(3120);
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== design/fixed_point_natural_log_core.sv =====
// Fixed-point natural log core, Q16.16 in, Q5.16 out, fully pipelined.
// Stages from an accepted word to its result: normalise, 15 divider stages, square,
// 11 Horner stages, final product, sum into the output register.
// Throughput: one word per cycle unless the output stalls; the divider and
// Horner unit are unrolled into pipeline stages. Stall freezes every stage.
// Reset clears valid bits only. Depends on fpln_pkg.
`default_nettype none
module fixed_point_natural_log_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 valid_i,
  output logic                                      stall_o,
  input  wire logic signed [fpln_pkg::InW-1:0]      value_q16_i,
  output logic                                      valid_o,
  input  wire logic                                 stall_i,
  output logic signed [fpln_pkg::LogW-1:0]          log_q16_o,
  output logic                                      invalid_o
);
  localparam int unsigned QW = fpln_pkg::QW;
  localparam int unsigned NT = fpln_pkg::NTerms;
  localparam int unsigned AW = fpln_pkg::AccW;
  localparam int unsigned YW = fpln_pkg::YW;
  localparam int unsigned MW = fpln_pkg::MantW;
  localparam int unsigned SumW = 24;

  logic adv;
  assign adv = !(valid_o && stall_i);
  assign stall_o = !adv;

  // ---------------- stage 0: normalise
  logic [5:0] clz;
  always_comb begin
    clz = 6'd32;
    for (int i = 0; i < 32; i++) if (value_q16_i[i]) clz = 6'(31 - i);
  end
  logic signed [5:0] e0;
  logic [MW-1:0] mant0;
  logic bad0;
  assign bad0 = value_q16_i[31] || (value_q16_i == '0);
  assign e0 = 6'sd16 - $signed(clz);
  always_comb begin
    logic [47:0] w;
    w = {16'd0, value_q16_i} << clz;   // leading one at bit 31
    mant0 = MW'(w[31:16]);
  end

  // Divider: y = -((65536-m)*65536 / (m+65536)); numerator < denominator/2,
  // so start from the doubled remainder and skip the always-zero top bit
  localparam int unsigned DS = QW;
  logic           dv_v_q [DS+1];
  logic           dv_b_q [DS+1];
  logic signed [5:0] dv_e_q [DS+1];
  logic [MW:0]    dv_r_q [DS+1];   // remainder
  logic [MW:0]    dv_d_q [DS+1];   // divisor
  logic [QW-1:0]  dv_q_q [DS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= DS; s++) dv_v_q[s] <= 1'b0;
    end else if (adv) begin
      dv_v_q[0] <= valid_i;
      for (int s = 1; s <= DS; s++) dv_v_q[s] <= dv_v_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_b_q[0] <= bad0;
      dv_e_q[0] <= e0;
      dv_r_q[0] <= (MW+1)'({17'd65536 - mant0, 1'b0});
      dv_d_q[0] <= (MW+1)'(mant0) + (MW+1)'(17'd65536);
      dv_q_q[0] <= '0;
      for (int s = 1; s <= DS; s++) begin
        logic [MW+1:0] t;
        t = {dv_r_q[s-1], 1'b0};
        dv_b_q[s] <= dv_b_q[s-1];
        dv_e_q[s] <= dv_e_q[s-1];
        dv_d_q[s] <= dv_d_q[s-1];
        if (t >= {1'b0, dv_d_q[s-1]}) begin
          dv_r_q[s] <= (MW+1)'(t - {1'b0, dv_d_q[s-1]});
          dv_q_q[s] <= {dv_q_q[s-1][QW-2:0], 1'b1};
        end else begin
          dv_r_q[s] <= (MW+1)'(t);
          dv_q_q[s] <= {dv_q_q[s-1][QW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- square
  logic signed [YW-1:0] y_q;
  logic signed [AW-1:0] ysq_q;
  logic sq_v_q, sq_b_q;
  logic signed [5:0] sq_e_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sq_v_q <= 1'b0;
    else if (adv) sq_v_q <= dv_v_q[DS];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic signed [YW-1:0] y;
      logic signed [2*YW-1:0] p;
      y = -$signed({2'b00, dv_q_q[DS]});
      p = y * y;
      y_q    <= y;
      ysq_q  <= AW'(p >>> 16);
      sq_b_q <= dv_b_q[DS];
      sq_e_q <= dv_e_q[DS];
    end
  end

  // ---------------- Horner: acc = asr16(acc*ysq) + c[k], k = 9..0
  logic              h_v_q [NT];
  logic              h_b_q [NT];
  logic signed [5:0] h_e_q [NT];
  logic signed [YW-1:0] h_y_q [NT];
  logic signed [AW-1:0] h_s_q [NT];
  logic signed [AW-1:0] h_a_q [NT];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NT; s++) h_v_q[s] <= 1'b0;
    end else if (adv) begin
      h_v_q[0] <= sq_v_q;
      for (int s = 1; s < NT; s++) h_v_q[s] <= h_v_q[s-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_b_q[0] <= sq_b_q; h_e_q[0] <= sq_e_q; h_y_q[0] <= y_q; h_s_q[0] <= ysq_q;
      h_a_q[0] <= fpln_pkg::series_coef(NT - 1);
      for (int s = 1; s < NT; s++) begin
        logic signed [2*AW-1:0] p;
        p = h_a_q[s-1] * h_s_q[s-1];
        h_b_q[s] <= h_b_q[s-1]; h_e_q[s] <= h_e_q[s-1];
        h_y_q[s] <= h_y_q[s-1]; h_s_q[s] <= h_s_q[s-1];
        h_a_q[s] <= AW'(p >>> 16) + fpln_pkg::series_coef(NT - 1 - s);
      end
    end
  end

  // ---------------- final product, then sum
  logic f_v_q, f_b_q;
  logic signed [5:0] f_e_q;
  logic signed [AW-1:0] f_a_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0; valid_o <= 1'b0;
    end else if (adv) begin
      f_v_q <= h_v_q[NT-1]; valid_o <= f_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic signed [AW+YW:0] p;
      logic signed [SumW-1:0] r;
      p = h_a_q[NT-1] * $signed({h_y_q[NT-1], 1'b0});
      f_a_q <= AW'(p >>> 16);
      f_b_q <= h_b_q[NT-1];
      f_e_q <= h_e_q[NT-1];
      r = SumW'(f_e_q) * SumW'(fpln_pkg::Ln2Q16) + SumW'(f_a_q);
      log_q16_o <= f_b_q ? '0 : fpln_pkg::LogW'(r);
      invalid_o <= f_b_q;
    end
  end
endmodule
`default_nettype wire

// ===== design/fpln_checker.sv =====
// Port checker for the natural log core, bound into every instance of the core below.
// Depends on fpln_pkg and the core.
`default_nettype none
module fpln_port_props (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic stall_o,
  input wire logic valid_o,
  input wire logic stall_i,
  input wire logic signed [fpln_pkg::LogW-1:0] log_q16_o,
  input wire logic invalid_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(log_q16_o) && $stable(invalid_o))
    else $error("output moved");
  a_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && invalid_o |-> log_q16_o == '0) else $error("invalid with value");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i) else $error("spurious stall");
endmodule
bind fixed_point_natural_log_core fpln_port_props u_chk (.*);
`default_nettype wire

// ===== bench/fpln_checker.sv =====
// Checker for the fixed-point natural log core: watches both channels, predicts
// each result from the accepted operand and compares it. Depends on fpln_pkg.
`default_nettype none
module fpln_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire logic                            stall_o,
  input  wire logic signed [fpln_pkg::InW-1:0] value_q16_i,
  input  wire logic                            valid_o,
  input  wire logic                            stall_i,
  input  wire logic signed [fpln_pkg::LogW-1:0] log_q16_o,
  input  wire logic                            invalid_o,
  output int                                   fail_count,
  output int                                   pending_count
);
  typedef struct packed {
    logic signed [fpln_pkg::LogW-1:0] log_q16;
    logic                             invalid;
  } log_result_t;

  log_result_t expected_logs[$];

  // Floor shift by 16, as an arithmetic shift of a 64-bit product.
  function automatic longint floor_q16(input longint p);
    floor_q16 = p >>> 16;
  endfunction

  function automatic log_result_t predict_log(input logic [fpln_pkg::InW-1:0] raw);
    log_result_t r;
    int          lz;
    int          expo;
    longint      mant, y, ysq, acc, sum;
    lz = 0;
    r.log_q16 = '0;
    r.invalid = 1'b1;
    if (raw[fpln_pkg::InW-1] || raw == '0) return r;
    while (raw[fpln_pkg::InW-1-lz] == 1'b0) lz++;
    expo = 16 - lz;
    if (expo > 0) mant = longint'(raw >> expo);
    else mant = longint'(raw) << (-expo);
    // signed division truncates toward zero
    y = ((mant - 65536) * 65536) / (mant + 65536);
    ysq = floor_q16(y * y);
    acc = 65536 / 21;
    for (int k = fpln_pkg::NTerms - 2; k >= 0; k--)
      acc = floor_q16(acc * ysq) + 65536 / (2 * k + 1);
    acc = floor_q16(acc * (y * 2));
    sum = longint'(expo) * 45426 + acc;
    r.log_q16 = sum[fpln_pkg::LogW-1:0];
    r.invalid = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    log_result_t want;
    if (!rst_ni) begin
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      if (valid_i && !stall_o) expected_logs.push_back(predict_log(value_q16_i));
      if (valid_o && !stall_i) begin
        if (expected_logs.size() == 0) begin
          $display("%0t: unexpected word log=%0d invalid=%0b", $time, log_q16_o, invalid_o);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_logs.pop_front();
          if (want.log_q16 !== log_q16_o || want.invalid !== invalid_o) begin
            $display("%0t: expected log=%0d invalid=%0b, actual log=%0d invalid=%0b",
                     $time, want.log_q16, want.invalid, log_q16_o, invalid_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= expected_logs.size();
    end
  end
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Top of the natural log core bench: clock, reset, operand stimulus, output
// stalls and verdict. Depends on fpln_pkg, fpln_checker and the core.
`default_nettype none
module tb_top;
  localparam int Latency    = 30;
  localparam int IdleLimit  = 5000;
  localparam int RandomOps  = 400;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             valid_i;
  logic                             stall_o;
  logic signed [fpln_pkg::InW-1:0]  value_q16_i;
  logic                             valid_o;
  logic                             stall_i;
  logic signed [fpln_pkg::LogW-1:0] log_q16_o;
  logic                             invalid_o;
  int                               fail_count;
  int                               pending_count;
  bit                               hold_mode;
  bit                               sink_done;
  int                               idle_cycles;

  fixed_point_natural_log_core DUT (.*);

  fpln_checker u_checker (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Mostly positive operands spread over every exponent, some noise.
  function automatic logic [fpln_pkg::InW-1:0] random_operand();
    logic [fpln_pkg::InW-1:0] v;
    int                       sh;
    v = $urandom();
    case ($urandom_range(0, 5))
      0:       return v;
      1:       return v >> $urandom_range(30, 31);
      default: begin
        sh = $urandom_range(1, 31);
        return v >> sh;
      end
    endcase
  endfunction

  task automatic send_word(input logic [fpln_pkg::InW-1:0] v);
    int g;
    g = gap_len();
    if (g > 0) begin
      valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    valid_i     <= 1'b1;
    value_q16_i <= v;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
  endtask

  // Output stalls; one long hold-off while the sender keeps offering.
  initial begin
    int g;
    stall_i <= 1'b1;
    @(posedge rst_ni);
    while (!sink_done) begin
      @(posedge clk_i);
      if (hold_mode) begin
        stall_i <= 1'b1;
        repeat (120) @(posedge clk_i);
        hold_mode = 1'b0;
        stall_i <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        stall_i <= (g > 0);
        if (g > 1) repeat (g - 1) @(posedge clk_i);
      end else begin
        stall_i <= 1'b0;
      end
    end
    stall_i <= 1'b0;
  end

  initial begin
    logic [fpln_pkg::InW-1:0] directed[$];
    directed = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                 32'h7FFF_FFFF, 32'h4000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                 32'h0001_0000, 32'h0000_8000, 32'h0001_FFFF, 32'h0000_FFFF,
                 32'h0002_0000, 32'h0002_B7E1, 32'h5555_5555, 32'hAAAA_AAAA,
                 32'h0000_C000, 32'h0001_8000, 32'h0001_7FFF, 32'h8000_0001};
    valid_i     <= 1'b0;
    value_q16_i <= '0;
    rst_ni      <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_word(directed[i]);
    // Pause until every result has come back.
    drain();
    hold_mode = 1'b1;
    for (int i = 0; i < RandomOps; i++) send_word(random_operand());
    drain();
    repeat (Latency + 8) @(posedge clk_i);
    sink_done = 1'b1;
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: cycles with no word moving on either channel.
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end
endmodule
`default_nettype wire

// ===== sim.f =====
design/fpln_pkg.sv
design/fixed_point_natural_log_core.sv
design/fpln_checker.sv
bench/fpln_checker.sv
bench/tb_top.sv
